>>> rtl/dnts_pkg.sv
package dnts_pkg;

  // Pipeline split: five stages form the ramp input, three form the pixel
  localparam int HAV_STAGES   = 5;
  localparam int SHADE_STAGES = 3;
  localparam int STAGES       = HAV_STAGES + SHADE_STAGES;

  localparam logic [63:0] ONE_Q62     = 64'h4000_0000_0000_0000;
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;

  // (2k)(2k+1) for k = 1..12, the Taylor divisors of the sine series
  localparam logic [63:0] SERIES_DIV [12] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
    64'd210, 64'd272, 64'd342, 64'd420, 64'd506, 64'd600
  };

  localparam logic [16:0] FULL_DAY  = 17'd65536;
  localparam logic [15:0] DARK_BASE = 16'd22938;
  localparam logic [15:0] DARK_SPAN = 16'd42598;

  typedef enum logic [1:0] {
    REG_SUN_LONGITUDE       = 2'd0,
    REG_TWILIGHT_WIDTH      = 2'd1,
    REG_TWILIGHT_RECIPROCAL = 2'd2,
    REG_SHADE_MODE          = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [31:0] day;
    logic [31:0] night;
  } pixel_pair_t;

  // Ramp decision: full day, full night, or distance into the band
  typedef struct packed {
    logic        full;
    logic        dark;
    logic [17:0] span;
  } ramp_t;

  // (a * b) >> 62, evaluated at elaboration only
  function automatic logic [63:0] qmul62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return prod[125:62];
  endfunction

  // Sine of a Q62 angle, rounded to fb fraction bits; table build only
  function automatic logic [63:0] sine_entry(input logic [63:0] x, input int fb);
    logic [63:0] x2;
    logic [63:0] s;
    logic [63:0] v;
    x2 = qmul62(x, x);
    s  = ONE_Q62;
    for (int k = 11; k >= 0; k--) begin
      s = ONE_Q62 - qmul62(x2, s) / SERIES_DIV[k];
    end
    v = qmul62(x, s);
    return (v + (64'd1 << (61 - fb))) >> (62 - fb);
  endfunction

endpackage

>>> rtl/dnts_sine_rom.sv
module dnts_sine_rom #(
  parameter int ENTRIES       = 1024,
  parameter int FRACTION_BITS = 15,
  localparam int INDEX_W      = $clog2(ENTRIES + 1)
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [INDEX_W-1:0]       index,
  output logic [FRACTION_BITS:0]   sine
);

  localparam logic [63:0] ANGLE_STEP = dnts_pkg::HALF_PI_Q62 / ENTRIES;
  localparam logic [63:0] ANGLE_REM  = dnts_pkg::HALF_PI_Q62 % ENTRIES;

  logic [FRACTION_BITS:0] sine_table [ENTRIES+1];

  // Quarter wave, entries 0 through ENTRIES inclusive
  for (genvar i = 0; i <= ENTRIES; i++) begin : g_entry
    localparam logic [63:0] ANGLE = ANGLE_STEP * i + (ANGLE_REM * i) / ENTRIES;
    localparam logic [63:0] VALUE = dnts_pkg::sine_entry(ANGLE, FRACTION_BITS);
    assign sine_table[i] = VALUE[FRACTION_BITS:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sine <= sine_table[index];
    end
  end

endmodule

>>> rtl/dnts_haversine.sv
module dnts_haversine #(
  parameter int ENTRIES       = 1024,
  parameter int FRACTION_BITS = 15
) (
  input  logic                                clk,
  input  logic [dnts_pkg::HAV_STAGES-1:0]     stage_en,
  input  logic signed [15:0]                  sun_longitude,
  input  logic [15:0]                         twilight_width,
  input  logic signed [15:0]                  longitude,
  input  logic signed [15:0]                  lat_half_sine,
  input  logic [15:0]                         cos_product,
  input  dnts_pkg::pixel_pair_t               pixel_in,
  output dnts_pkg::ramp_t                     ramp,
  output dnts_pkg::pixel_pair_t               pixel_out
);

  localparam int FB      = FRACTION_BITS;
  localparam int INDEX_W = $clog2(ENTRIES + 1);
  localparam int PROD_W  = 16 + INDEX_W;
  localparam int H_W     = FB + 17;
  localparam int SH_UP   = (FB >= 15) ? FB - 15 : 0;
  localparam int SH_DN   = (FB >= 15) ? 0 : 15 - FB;
  localparam int LAT_W   = 31 + SH_UP;

  // Stage 1: table index and latitude square
  logic [15:0]         angle_diff;
  logic [15:0]         mirror;
  logic [PROD_W-1:0]   index_prod;
  logic [INDEX_W:0]    index_raw;
  logic [INDEX_W-1:0]  index_sel;
  logic [15:0]         lat_abs;
  logic [31:0]         lat_prod;

  logic [INDEX_W-1:0]          index1;
  logic [30:0]                 lat_sq1;
  logic [15:0]                 cos1;
  dnts_pkg::pixel_pair_t       pix1;

  always_comb begin
    angle_diff = longitude - sun_longitude;
    mirror     = angle_diff[15] ? 16'(17'h1_0000 - {1'b0, angle_diff}) : angle_diff;
    index_prod = PROD_W'(mirror) * PROD_W'(ENTRIES) + PROD_W'(16384);
    index_raw  = index_prod[PROD_W-1:15];
    if (index_raw > (INDEX_W+1)'(ENTRIES)) begin
      index_sel = INDEX_W'(ENTRIES);
    end else begin
      index_sel = index_raw[INDEX_W-1:0];
    end
    lat_abs  = lat_half_sine[15] ? 16'(~lat_half_sine + 16'sd1) : lat_half_sine;
    lat_prod = {16'd0, lat_abs} * {16'd0, lat_abs};
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      index1  <= index_sel;
      lat_sq1 <= lat_prod[30:0];
      cos1    <= cos_product;
      pix1    <= pixel_in;
    end
  end

  // Stage 2: sine lookup
  logic [FB:0]                 sine2;
  logic [30:0]                 lat_sq2;
  logic [15:0]                 cos2;
  dnts_pkg::pixel_pair_t       pix2;

  dnts_sine_rom #(
    .ENTRIES       (ENTRIES),
    .FRACTION_BITS (FB)
  ) u_rom (
    .clk   (clk),
    .en    (stage_en[1]),
    .index (index1),
    .sine  (sine2)
  );

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      lat_sq2 <= lat_sq1;
      cos2    <= cos1;
      pix2    <= pix1;
    end
  end

  // Stage 3: sine squared, truncated
  logic [2*FB+1:0]             sine_prod;
  logic [FB:0]                 sine_sq3;
  logic [30:0]                 lat_sq3;
  logic [15:0]                 cos3;
  dnts_pkg::pixel_pair_t       pix3;

  assign sine_prod = (2*FB+2)'(sine2) * (2*FB+2)'(sine2);

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      sine_sq3 <= sine_prod[2*FB:FB];
      lat_sq3  <= lat_sq2;
      cos3     <= cos2;
      pix3     <= pix2;
    end
  end

  // Stage 4: cosine product term, latitude term aligned to Q(15+FB)
  logic [H_W-1:0]              cos_term;
  logic [LAT_W-1:0]            lat_shift;
  logic [H_W-1:0]              cos_term4;
  logic [H_W-1:0]              lat_term4;
  dnts_pkg::pixel_pair_t       pix4;

  assign cos_term  = H_W'(cos3) * H_W'(sine_sq3);
  assign lat_shift = (LAT_W'(lat_sq3) << SH_UP) >> SH_DN;

  always_ff @(posedge clk) begin
    if (stage_en[3]) begin
      cos_term4 <= cos_term;
      lat_term4 <= H_W'(lat_shift);
      pix4      <= pix3;
    end
  end

  // Stage 5: haversine to Q2.16, band compares
  logic [H_W-1:0]  hav;
  logic [H_W-1:0]  hav_round;
  logic [17:0]     hav16;
  logic [19:0]     two_h;
  logic [19:0]     band_hi;
  dnts_pkg::ramp_t ramp_next;

  always_comb begin
    hav       = lat_term4 + cos_term4;
    hav_round = hav + (H_W'(1) << (FB - 2));
    hav16     = hav_round[FB+16:FB-1];
    two_h     = {1'b0, hav16, 1'b0};
    band_hi   = 20'd65536 + 20'(twilight_width);
    ramp_next.full = (two_h + 20'(twilight_width)) <= 20'd65536;
    ramp_next.dark = two_h >= band_hi;
    ramp_next.span = 18'(band_hi - two_h);
  end

  always_ff @(posedge clk) begin
    if (stage_en[4]) begin
      ramp      <= ramp_next;
      pixel_out <= pix4;
    end
  end

endmodule

>>> rtl/dnts_shade.sv
module dnts_shade (
  input  logic                                clk,
  input  logic [dnts_pkg::SHADE_STAGES-1:0]   stage_en,
  input  logic [15:0]                         twilight_reciprocal,
  input  logic                                shade_mode,
  input  dnts_pkg::ramp_t                     ramp,
  input  dnts_pkg::pixel_pair_t               pixel_in,
  output logic [31:0]                         shaded_argb,
  output logic [16:0]                         brightness_level
);

  // Stage 6: ramp through the preloaded reciprocal, saturate
  logic [33:0]           ramp_prod;
  logic [24:0]           ramp_val;
  logic [16:0]           bright_next;
  logic [16:0]           bright6;
  dnts_pkg::pixel_pair_t pix6;

  always_comb begin
    ramp_prod = 34'(ramp.span) * 34'(twilight_reciprocal) + 34'd256;
    ramp_val  = ramp_prod[33:9];
    if (ramp.full) begin
      bright_next = dnts_pkg::FULL_DAY;
    end else if (ramp.dark) begin
      bright_next = '0;
    end else if (ramp_val > 25'(dnts_pkg::FULL_DAY)) begin
      bright_next = dnts_pkg::FULL_DAY;
    end else begin
      bright_next = ramp_val[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[0]) begin
      bright6 <= bright_next;
      pix6    <= pixel_in;
    end
  end

  // Stage 7: darken factor and blend complement
  logic [32:0]           factor_prod;
  logic [16:0]           bright7;
  logic [16:0]           factor7;
  logic [16:0]           inverse7;
  dnts_pkg::pixel_pair_t pix7;

  assign factor_prod = 33'(dnts_pkg::DARK_SPAN) * 33'(bright6);

  always_ff @(posedge clk) begin
    if (stage_en[1]) begin
      bright7  <= bright6;
      factor7  <= 17'(dnts_pkg::DARK_BASE) + factor_prod[32:16];
      inverse7 <= dnts_pkg::FULL_DAY - bright6;
      pix7     <= pix6;
    end
  end

  // Stage 8: per-channel scale or blend, then pick the pixel
  logic [23:0] scaled;
  logic [23:0] blended;
  logic [24:0] scale_prod;
  logic [24:0] day_prod;
  logic [24:0] night_prod;
  logic [25:0] blend_sum;
  logic [31:0] result;

  always_comb begin
    scaled  = '0;
    blended = '0;
    for (int ch = 0; ch < 3; ch++) begin
      scale_prod = 25'(pix7.day[8*ch +: 8]) * 25'(factor7);
      day_prod   = 25'(pix7.day[8*ch +: 8]) * 25'(bright7);
      night_prod = 25'(pix7.night[8*ch +: 8]) * 25'(inverse7);
      blend_sum  = 26'(day_prod) + 26'(night_prod);
      scaled[8*ch +: 8]  = scale_prod[23:16];
      blended[8*ch +: 8] = blend_sum[23:16];
    end
    if (bright7 == dnts_pkg::FULL_DAY) begin
      result = pix7.day;
    end else if (!shade_mode) begin
      result = {8'hFF, scaled};
    end else if (bright7 == '0) begin
      result = pix7.night;
    end else begin
      result = {8'hFF, blended};
    end
  end

  always_ff @(posedge clk) begin
    if (stage_en[2]) begin
      shaded_argb      <= result;
      brightness_level <= bright7;
    end
  end

endmodule

>>> rtl/day_night_terminator_shader.sv
// Path: one register per stage between an accepted pixel and shade_valid.
// Throughput: one pixel per cycle while shade_stall does not hold a full pipeline;
// the sine table has a single read port. Empty stages fill while the output waits.
// Reset clears all stage valid bits and loads the configuration registers with their
// defaults; the sine table is constant and needs no fill.
module day_night_terminator_shader #(
  parameter int SINE_TABLE_ENTRIES = 1024,
  parameter int FRACTION_BITS      = 15
) (
  input  logic               clk,
  input  logic               rst,

  input  logic               pixel_valid,
  output logic               pixel_stall,
  input  logic signed [15:0] longitude,
  input  logic signed [15:0] lat_half_sine,
  input  logic [15:0]        cos_product,
  input  logic [31:0]        day_argb,
  input  logic [31:0]        night_argb,

  output logic               shade_valid,
  input  logic               shade_stall,
  output logic [31:0]        shaded_argb,
  output logic [16:0]        brightness_level,

  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int STAGES = dnts_pkg::STAGES;
  localparam int HAV    = dnts_pkg::HAV_STAGES;

  // Configuration registers
  logic signed [15:0] sun_longitude;
  logic [15:0]        twilight_width;
  logic [15:0]        twilight_reciprocal;
  logic               shade_mode;
  logic               cfg_write;
  dnts_pkg::reg_index_t cfg_sel;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_sel   = dnts_pkg::reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      sun_longitude       <= '0;
      twilight_width      <= 16'd6554;
      twilight_reciprocal <= 16'd2560;
      shade_mode          <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        dnts_pkg::REG_SUN_LONGITUDE:       sun_longitude       <= pwdata[15:0];
        dnts_pkg::REG_TWILIGHT_WIDTH:      twilight_width      <= pwdata[15:0];
        dnts_pkg::REG_TWILIGHT_RECIPROCAL: twilight_reciprocal <= pwdata[15:0];
        dnts_pkg::REG_SHADE_MODE:          shade_mode          <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      dnts_pkg::REG_SUN_LONGITUDE:       prdata = {{16{sun_longitude[15]}}, sun_longitude};
      dnts_pkg::REG_TWILIGHT_WIDTH:      prdata = {16'd0, twilight_width};
      dnts_pkg::REG_TWILIGHT_RECIPROCAL: prdata = {16'd0, twilight_reciprocal};
      dnts_pkg::REG_SHADE_MODE:          prdata = {31'd0, shade_mode};
    endcase
  end

  // Stage control: a stage loads when it is empty or the one after it moves
  logic [STAGES:1] vld;
  logic [STAGES:1] vld_next;
  logic [STAGES:1] en;

  always_comb begin
    en[STAGES] = !vld[STAGES] || !shade_stall;
    for (int k = STAGES - 1; k >= 1; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign vld_next    = {vld[STAGES-1:1], pixel_valid};
  assign pixel_stall = !en[1];
  assign shade_valid = vld[STAGES];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 1; k <= STAGES; k++) begin
        if (en[k]) begin
          vld[k] <= vld_next[k];
        end
      end
    end
  end

  // Datapath
  dnts_pkg::pixel_pair_t pixel_in;
  dnts_pkg::pixel_pair_t pixel_mid;
  dnts_pkg::ramp_t       ramp;

  assign pixel_in.day   = day_argb;
  assign pixel_in.night = night_argb;

  dnts_haversine #(
    .ENTRIES       (SINE_TABLE_ENTRIES),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_haversine (
    .clk            (clk),
    .stage_en       (en[HAV:1]),
    .sun_longitude  (sun_longitude),
    .twilight_width (twilight_width),
    .longitude      (longitude),
    .lat_half_sine  (lat_half_sine),
    .cos_product    (cos_product),
    .pixel_in       (pixel_in),
    .ramp           (ramp),
    .pixel_out      (pixel_mid)
  );

  dnts_shade u_shade (
    .clk                 (clk),
    .stage_en            (en[STAGES:HAV+1]),
    .twilight_reciprocal (twilight_reciprocal),
    .shade_mode          (shade_mode),
    .ramp                (ramp),
    .pixel_in            (pixel_mid),
    .shaded_argb         (shaded_argb),
    .brightness_level    (brightness_level)
  );

  // Input stalls only when every stage holds a pixel and the output is stalled
  a_stall_only_full: assert property (@(posedge clk) disable iff (rst)
    pixel_stall |-> ((&vld) && shade_stall))
    else $error("input stalled with an empty stage");

  a_bright_range: assert property (@(posedge clk) disable iff (rst)
    shade_valid |-> (brightness_level <= dnts_pkg::FULL_DAY))
    else $error("brightness above full day");

  a_twilight_alpha: assert property (@(posedge clk) disable iff (rst)
    (shade_valid && brightness_level != '0 && brightness_level != dnts_pkg::FULL_DAY)
      |-> (shaded_argb[31:24] == 8'hFF))
    else $error("twilight pixel without opaque alpha");

endmodule
